>>> sv/tgb_pkg.sv
// shared types, constants and helpers for the triangle grid binning unit
package tgb_pkg;

	localparam int VERT_W      = 15;
	localparam int SCALE_W     = 16;
	localparam int DIV_W       = 3;
	localparam int IDX_W       = 2;
	localparam int CELL_W      = 6;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int INDEX_SHIFT = 26;
	localparam int NUM_AXES    = 3;
	localparam int MAP_STEPS   = 2 * NUM_AXES;
	localparam int STEP_W      = 3;

	localparam logic [32:0] WORLD_BIAS = 33'd10240;

	localparam logic [DIV_W-1:0]   DIVISIONS_RESET  = 3'd4;
	localparam logic [SCALE_W-1:0] CELL_SCALE_RESET = 16'd13107;

	localparam logic [CFG_INDEX_W-1:0] REG_DIVISIONS  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CELL_SCALE = 2'd1;

	typedef logic [IDX_W-1:0] grid_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAP,
		ST_HAND
	} tgb_state_t;

	typedef struct packed {
		logic [NUM_AXES-1:0][IDX_W-1:0] lo;
		logic [NUM_AXES-1:0][IDX_W-1:0] hi;
		logic [DIV_W-1:0]               div;
		logic                           clamp;
	} walk_cmd_t;

	function automatic logic [CELL_W-1:0] lin_index(
		input logic [DIV_W-1:0] d,
		input grid_idx_t        i,
		input grid_idx_t        j,
		input grid_idx_t        k
	);
		logic [7:0] dd;
		logic [7:0] sum;
		dd  = 8'(d) * 8'(d);
		sum = 8'(i) + 8'(d) * 8'(j) + dd * 8'(k);
		return sum[CELL_W-1:0];
	endfunction

endpackage

>>> sv/tgb_index_unit.sv
// shared coordinate to grid index unit: bias, scale multiply, clamp
module tgb_index_unit
	import tgb_pkg::*;
#(
	parameter int COORD_WIDTH = 16
) (
	input  logic                      clk,
	input  logic                      load,
	input  logic signed [VERT_W-1:0]  coord,
	input  logic [SCALE_W-1:0]        scale,
	input  logic [DIV_W-1:0]          div,
	output grid_idx_t                 idx,
	output logic                      clamp
);

	localparam int PW = COORD_WIDTH + SCALE_W;
	localparam int QW = PW - INDEX_SHIFT;
	localparam int CW = QW + DIV_W;

	logic [32:0]            sum;
	logic [COORD_WIDTH-1:0] biased_s1;
	logic [PW-1:0]          prod;
	logic [QW-1:0]          quot;
	logic                   neg;
	logic                   over;
	logic [DIV_W-1:0]       dm1;

	assign sum = {{(33 - VERT_W){coord[VERT_W-1]}}, coord} + WORLD_BIAS;

	always_ff @(posedge clk) begin
		if (load) begin
			biased_s1 <= sum[COORD_WIDTH-1:0];
		end
	end

	assign neg  = biased_s1[COORD_WIDTH-1];
	assign prod = PW'(biased_s1) * PW'(scale);
	assign quot = prod[PW-1:INDEX_SHIFT];
	assign over = CW'(quot) >= CW'(div);
	assign dm1  = div - DIV_W'(1);

	always_comb begin
		if (neg) begin
			idx = '0;
		end else if (over) begin
			idx = dm1[IDX_W-1:0];
		end else begin
			idx = quot[IDX_W-1:0];
		end
	end

	assign clamp = neg | over;

endmodule

>>> sv/tgb_cell_walker.sv
// walks the covered cell range and drives the result channel
module tgb_cell_walker
	import tgb_pkg::*;
#(
	parameter int TAG_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  walk_cmd_t            cmd,
	input  logic [TAG_WIDTH-1:0] tag,
	output logic                 ready,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [TAG_WIDTH-1:0] out_tag,
	output logic [CELL_W-1:0]    cell_index,
	output logic                 out_of_range,
	output logic                 last_cell
);

	logic                 valid_q;
	walk_cmd_t            cmd_q;
	logic [TAG_WIDTH-1:0] tag_q;
	grid_idx_t            i_q, j_q, k_q;
	logic [CELL_W-1:0]    cell_q;
	logic                 last_q;
	logic                 xfer;
	grid_idx_t            ni, nj, nk;

	assign xfer  = valid_q & ~out_stall;
	assign ready = ~valid_q | (xfer & last_q);

	always_comb begin
		ni = i_q;
		nj = j_q;
		nk = k_q;
		if (k_q != cmd_q.hi[2]) begin
			nk = k_q + IDX_W'(1);
		end else if (j_q != cmd_q.hi[1]) begin
			nj = j_q + IDX_W'(1);
			nk = cmd_q.lo[2];
		end else begin
			ni = i_q + IDX_W'(1);
			nj = cmd_q.lo[1];
			nk = cmd_q.lo[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (start) begin
			valid_q <= 1'b1;
		end else if (xfer && last_q) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cmd_q  <= cmd;
			tag_q  <= tag;
			i_q    <= cmd.lo[0];
			j_q    <= cmd.lo[1];
			k_q    <= cmd.lo[2];
			cell_q <= lin_index(cmd.div, cmd.lo[0], cmd.lo[1], cmd.lo[2]);
			last_q <= (cmd.lo == cmd.hi);
		end else if (xfer && !last_q) begin
			i_q    <= ni;
			j_q    <= nj;
			k_q    <= nk;
			cell_q <= lin_index(cmd_q.div, ni, nj, nk);
			last_q <= (ni == cmd_q.hi[0]) && (nj == cmd_q.hi[1]) && (nk == cmd_q.hi[2]);
		end
	end

	assign out_valid    = valid_q;
	assign out_tag      = tag_q;
	assign cell_index   = cell_q;
	assign out_of_range = cmd_q.clamp;
	assign last_cell    = last_q;

endmodule

>>> sv/triangle_grid_binning_unit.sv
// top level of the triangle grid binning unit: config, sequencer, index unit, walker
//
// One triangle (three vertices, Q5.10, plus a tag) is taken on the input channel
// when in_valid is high and in_stall is low. The unit then runs its bounding box
// through one shared index unit (bias, multiply by cell_scale, shift, clamp), one
// corner coordinate per cycle (six coordinates), and then hands the cell range to
// the walker. The input channel is stalled while mapping and during the hand-off,
// and longer while the hand-off waits for the walker to finish earlier results.
// The walker emits one result per covered cell, one per cycle while out_stall is low;
// the first result is registered by the walker at the hand-off. The last result of a
// triangle has last_cell set, and out_of_range is the same on all of its results.
// While out_stall is high the current result holds, and the next triangle is mapped
// meanwhile but waits in the hand-off state until the walker has sent its last cell.
// Configuration writes (divisions, cell_scale) use cfg_valid/cfg_ready, are always
// accepted, and must only be issued while the unit is idle. Reset clears the
// sequencer and the result valid and loads divisions 4, cell_scale 13107.
module triangle_grid_binning_unit
	import tgb_pkg::*;
#(
	parameter int MAX_DIVISIONS = 4,
	parameter int COORD_WIDTH   = 16,
	parameter int TAG_WIDTH     = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_INDEX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [VERT_W-1:0]      vert_a_x,
	input  logic signed [VERT_W-1:0]      vert_a_y,
	input  logic signed [VERT_W-1:0]      vert_a_z,
	input  logic signed [VERT_W-1:0]      vert_b_x,
	input  logic signed [VERT_W-1:0]      vert_b_y,
	input  logic signed [VERT_W-1:0]      vert_b_z,
	input  logic signed [VERT_W-1:0]      vert_c_x,
	input  logic signed [VERT_W-1:0]      vert_c_y,
	input  logic signed [VERT_W-1:0]      vert_c_z,
	input  logic [TAG_WIDTH-1:0]          tri_tag,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [TAG_WIDTH-1:0]          out_tag,
	output logic [CELL_W-1:0]             cell_index,
	output logic                          out_of_range,
	output logic                          last_cell
);

	tgb_state_t state_q, state_d;

	logic [DIV_W-1:0]   div_q;
	logic [SCALE_W-1:0] scale_q;
	logic [DIV_W-1:0]   div_eff;

	logic signed [VERT_W-1:0] ax_q[3];
	logic signed [VERT_W-1:0] ay_q[3];
	logic signed [VERT_W-1:0] az_q[3];
	logic [TAG_WIDTH-1:0]     tag_q;

	logic [STEP_W-1:0]              step_q;
	logic [STEP_W-1:0]              tgt;
	logic [NUM_AXES-1:0][IDX_W-1:0] lo_q, hi_q;
	logic                           flag_q;

	logic                     accept;
	logic                     load;
	logic                     wb;
	logic                     walk_start;
	logic                     walk_ready;
	logic signed [VERT_W-1:0] mn, mx, sel;
	grid_idx_t                idx;
	logic                     clamp;
	walk_cmd_t                cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q   <= DIVISIONS_RESET;
			scale_q <= CELL_SCALE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DIVISIONS:  div_q   <= cfg_data[DIV_W-1:0];
				REG_CELL_SCALE: scale_q <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (div_q == '0) begin
			div_eff = DIV_W'(1);
		end else if (div_q > DIV_W'(MAX_DIVISIONS)) begin
			div_eff = DIV_W'(MAX_DIVISIONS);
		end else begin
			div_eff = div_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_stall   = 1'b1;
		walk_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_MAP;
				end
			end
			ST_MAP: begin
				if (step_q == STEP_W'(MAP_STEPS)) begin
					state_d = ST_HAND;
				end
			end
			ST_HAND: begin
				if (walk_ready) begin
					walk_start = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign accept = in_valid & ~in_stall;
	assign load   = (state_q == ST_MAP) && (step_q < STEP_W'(MAP_STEPS));
	assign wb     = (state_q == ST_MAP) && (step_q != '0);
	assign tgt    = step_q - STEP_W'(1);

	// min and max over the three vertices of the axis at the head of the rotation
	always_comb begin
		mn = ax_q[0];
		mx = ax_q[0];
		if (ax_q[1] < mn) mn = ax_q[1];
		if (ax_q[2] < mn) mn = ax_q[2];
		if (ax_q[1] > mx) mx = ax_q[1];
		if (ax_q[2] > mx) mx = ax_q[2];
		sel = step_q[0] ? mx : mn;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (accept) begin
			step_q <= '0;
		end else if (state_q == ST_MAP) begin
			step_q <= step_q + STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ax_q[0] <= vert_a_x;
			ax_q[1] <= vert_b_x;
			ax_q[2] <= vert_c_x;
			ay_q[0] <= vert_a_y;
			ay_q[1] <= vert_b_y;
			ay_q[2] <= vert_c_y;
			az_q[0] <= vert_a_z;
			az_q[1] <= vert_b_z;
			az_q[2] <= vert_c_z;
			tag_q   <= tri_tag;
			flag_q  <= 1'b0;
		end else begin
			if (load && step_q[0]) begin
				ax_q <= ay_q;
				ay_q <= az_q;
			end
			if (wb) begin
				if (tgt[0]) begin
					hi_q[tgt[2:1]] <= idx;
				end else begin
					lo_q[tgt[2:1]] <= idx;
				end
				flag_q <= flag_q | clamp;
			end
		end
	end

	tgb_index_unit #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_index (
		.clk   (clk),
		.load  (load),
		.coord (sel),
		.scale (scale_q),
		.div   (div_eff),
		.idx   (idx),
		.clamp (clamp)
	);

	assign cmd.lo    = lo_q;
	assign cmd.hi    = hi_q;
	assign cmd.div   = div_eff;
	assign cmd.clamp = flag_q;

	tgb_cell_walker #(
		.TAG_WIDTH(TAG_WIDTH)
	) u_walker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (walk_start),
		.cmd          (cmd),
		.tag          (tag_q),
		.ready        (walk_ready),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_tag      (out_tag),
		.cell_index   (cell_index),
		.out_of_range (out_of_range),
		.last_cell    (last_cell)
	);

endmodule
